### src/rac_pkg.sv
// Shared types and constants for the residual autocorrelation monitor.
// No dependencies; imported by every module of the block except rac_div.
`timescale 1ns / 1ps
`default_nettype none
package rac_pkg;

   // register indexes on the csr channel
   localparam logic [2:0] CSR_WINDOW    = 3'd0;
   localparam logic [2:0] CSR_MIN_FILL  = 3'd1;
   localparam logic [2:0] CSR_ADAPT     = 3'd2;
   localparam logic [2:0] CSR_STAT_LOW  = 3'd3;
   localparam logic [2:0] CSR_STAT_HIGH = 3'd4;

   localparam logic [6:0]  WINDOW_RST    = 7'd32;
   localparam logic [6:0]  MIN_FILL_RST  = 7'd10;
   localparam logic [15:0] ADAPT_RST     = 16'd655;
   localparam logic [14:0] STAT_LOW_RST  = 15'd6144;
   localparam logic [14:0] STAT_HIGH_RST = 15'd10240;

   // Durbin-Watson 2.0 and 4.0 in unsigned Q3.12
   localparam logic [14:0] DW_TWO  = 15'd8192;
   localparam logic [14:0] DW_FOUR = 15'd16384;

   typedef struct packed {
      logic [6:0]  window_size;
      logic [6:0]  min_fill;
      logic [15:0] adapt_rate;
      logic [14:0] stat_low;
      logic [14:0] stat_high;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] sample;
      logic               seed;
      logic [31:0]        count;
   } item_type;

endpackage
`default_nettype wire

### src/rac_front.sv
// Front end: accepts samples, tags the seeding transaction and numbers each one.
// Depends on rac_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rac_front
   import rac_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_sample,
   input  wire logic               q_full,
   output logic                    q_push,
   output item_type                q_item
);

   logic        seeded_ff, seeded_in;
   logic [31:0] count_ff, count_in;

   assign req_stall = q_full;
   assign q_push    = req_valid & ~q_full;
   assign count_in  = count_ff + 32'd1;
   assign seeded_in = seeded_ff | q_push;

   always_comb begin
      q_item.sample = req_sample;
      q_item.seed   = ~seeded_ff;
      q_item.count  = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         seeded_ff <= seeded_in;
         if (q_push) begin
            count_ff <= count_in;
         end
      end
   end

endmodule
`default_nettype wire

### src/rac_fifo.sv
// Two-entry queue between the front end and the compute back end.
// Depends on rac_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rac_fifo
   import rac_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   output logic          nonempty,
   input  wire logic     pop,
   output item_type      head_item
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] used_ff, used_in;

   assign full      = (used_ff == 2'd2);
   assign nonempty  = (used_ff != 2'd0);
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      used_in = used_ff;
      if (push && !pop) begin
         used_in = used_ff + 2'd1;
      end else if (pop && !push) begin
         used_in = used_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         used_ff   <= '0;
      end else begin
         used_ff <= used_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

endmodule
`default_nettype wire

### src/rac_div.sv
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// Standalone; the remainder starts at rem_init and low bits shift in MSB first.
`timescale 1ns / 1ps
`default_nettype none
module rac_div #(
   parameter int REM_W = 71
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [REM_W-1:0] rem_init,
   input  wire logic [63:0]      low_bits,
   input  wire logic [REM_W-1:0] denom,
   input  wire logic [6:0]       steps,
   output logic                  done,
   output logic [63:0]           quot
);

   logic [REM_W-1:0] rem_ff, rem_in, den_ff;
   logic [63:0]      low_ff, quot_ff, quot_in;
   logic [6:0]       left_ff;
   logic             done_ff;
   logic [REM_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, low_ff[63]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in  = fits ? REM_W'(trial - {1'b0, den_ff}) : trial[REM_W-1:0];
      quot_in = {quot_ff[62:0], fits};
   end

   assign done = done_ff;
   assign quot = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            left_ff <= steps;
            rem_ff  <= rem_init;
            low_ff  <= low_bits;
            den_ff  <= denom;
            quot_ff <= '0;
         end else if (left_ff != 7'd0) begin
            left_ff <= left_ff - 7'd1;
            rem_ff  <= rem_in;
            low_ff  <= {low_ff[62:0], 1'b0};
            quot_ff <= quot_in;
            done_ff <= (left_ff == 7'd1);
         end
      end
   end

endmodule
`default_nettype wire

### src/rac_back.sv
// Back end: coefficient update, residual ring with running sums, Durbin-Watson.
// Depends on rac_pkg and rac_div; holds the result register.
`timescale 1ns / 1ps
`default_nettype none
module rac_back
   import rac_pkg::*;
#(
   parameter int WINDOW_MAX = 64
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     ring_clear,
   input  wire logic     q_nonempty,
   input  wire item_type q_item,
   output logic          q_pop,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output logic [14:0]   rsp_dw_stat,
   output logic          rsp_dw_valid,
   output logic signed [31:0] rsp_ar_coeff,
   output logic signed [31:0] rsp_residual,
   output logic          rsp_alarm,
   output logic [31:0]   rsp_alarm_count,
   output logic [31:0]   rsp_item_count
);

   localparam int IDX_W = (WINDOW_MAX > 2) ? $clog2(WINDOW_MAX) : 1;
   localparam int FILL_W = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W = 65 + $clog2(WINDOW_MAX);

   typedef enum logic [4:0] {
      ST_IDLE, ST_MUL1, ST_ERR0, ST_SCALE, ST_STARTA, ST_DIVA, ST_MUL2, ST_RES,
      ST_RD0, ST_RD1, ST_RD2, ST_SQ, ST_ACC, ST_CHK, ST_DIVB, ST_BAND, ST_OUT
   } state_type;

   function automatic logic [31:0] sat32(input logic signed [64:0] v);
      logic [31:0] r;
      if (v > 65'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (v < -65'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   state_type state_ff, state_in;
   logic signed [31:0] x_ff, x_in, prev_ff, prev_in, coeff_ff, coeff_in;
   logic signed [31:0] lres_ff, lres_in, plast_ff, plast_in, old0_ff, old0_in;
   logic signed [31:0] old1_ff, old1_in;
   logic [31:0]        cnt_ff, cnt_in, atot_ff, atot_in;
   logic signed [63:0] prod_ff, prod_in, e_ff, e_in;
   logic [62:0]        num_ff, num_in;
   logic               neg_ff, neg_in, inband_ff, inband_in;
   logic [14:0]        last_stat_ff, last_stat_in, dw_ff, dw_in;
   logic               valid_ff, valid_in, alarm_ff, alarm_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [SUM_W-1:0]   s_ff, s_in, d_ff, d_in;
   logic [65:0]        sq_ff, sq_in;
   logic [1:0]         step_ff, step_in;

   logic               rvalid_ff, rvalid_in;
   logic [14:0]        rdw_ff;
   logic               rdwv_ff, ralarm_ff;
   logic signed [31:0] rcoeff_ff, rres_ff;
   logic [31:0]        racnt_ff, ricnt_ff;
   logic               load;

   logic signed [31:0] ring_mem [WINDOW_MAX];
   logic signed [31:0] rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;

   logic [FILL_W-1:0]  win;
   logic [IDX_W-1:0]   head_norm, head_next;
   logic signed [63:0] x_ext, mul_ap;
   logic [63:0]        e_mag;
   logic [32:0]        p_mag, sq_op;
   logic signed [32:0] diff;
   logic signed [64:0] delta, e_adj;
   logic               div_start, div_done;
   logic [SUM_W-1:0]   div_rem, div_den;
   logic [63:0]        div_low, div_quot;
   logic [6:0]         div_steps;
   logic               in_ok;

   rac_div #(.REM_W(SUM_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem),
      .low_bits (div_low),
      .denom    (div_den),
      .steps    (div_steps),
      .done     (div_done),
      .quot     (div_quot)
   );

   // effective window, clamped to [2, WINDOW_MAX]
   always_comb begin
      if (32'(cfg.window_size) < 32'd2) begin
         win = FILL_W'(2);
      end else if (32'(cfg.window_size) > 32'(WINDOW_MAX)) begin
         win = FILL_W'(WINDOW_MAX);
      end else begin
         win = FILL_W'(cfg.window_size);
      end
   end

   assign head_norm = (FILL_W'(head_ff) >= win) ? '0 : head_ff;
   assign head_next = ((FILL_W'(head_ff) + FILL_W'(1)) == win) ? '0 :
                      IDX_W'(FILL_W'(head_ff) + FILL_W'(1));

   assign x_ext  = {{8{x_ff[31]}}, x_ff, 24'd0};
   assign mul_ap = coeff_ff * prev_ff;
   assign e_mag  = e_ff[63] ? 64'(-e_ff) : 64'(e_ff);
   assign p_mag  = prev_ff[31] ? 33'(-{prev_ff[31], prev_ff}) : {1'b0, prev_ff};
   assign delta  = neg_ff ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
   assign e_adj  = {e_in[63], e_in} + (e_in[63] ? 65'sd16777215 : 65'sd0);
   assign in_ok  = (dw_ff >= cfg.stat_low) && (dw_ff <= cfg.stat_high);
   assign load   = (state_ff == ST_OUT) && (!rvalid_ff || !rsp_stall);

   // squared operand for the running sums
   always_comb begin
      diff = '0;
      case (step_ff)
         2'd0: diff = 33'(lres_ff);
         2'd1: diff = 33'(lres_ff) - 33'(plast_ff);
         2'd2: diff = 33'(old0_ff);
         default: diff = 33'(old1_ff) - 33'(old0_ff);
      endcase
      sq_op = diff[32] ? 33'(-diff) : 33'(diff);
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      cnt_in       = cnt_ff;
      prev_in      = prev_ff;
      coeff_in     = coeff_ff;
      lres_in      = lres_ff;
      plast_in     = plast_ff;
      old0_in      = old0_ff;
      old1_in      = old1_ff;
      prod_in      = prod_ff;
      e_in         = e_ff;
      num_in       = num_ff;
      neg_in       = neg_ff;
      inband_in    = inband_ff;
      last_stat_in = last_stat_ff;
      dw_in        = dw_ff;
      valid_in     = valid_ff;
      alarm_in     = alarm_ff;
      atot_in      = atot_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      s_in         = s_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      step_in      = step_ff;
      q_pop        = 1'b0;
      rd_addr      = head_ff;
      wr_en        = 1'b0;
      div_start    = 1'b0;
      div_rem      = '0;
      div_low      = {num_ff, 1'b0};
      div_den      = SUM_W'(p_mag);
      div_steps    = 7'd63;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_nonempty) begin
               q_pop  = 1'b1;
               x_in   = q_item.sample;
               cnt_in = q_item.count;
               if (q_item.seed) begin
                  prev_in  = q_item.sample;
                  dw_in    = last_stat_ff;
                  valid_in = 1'b0;
                  alarm_in = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_MUL1;
               end
            end
         end
         ST_MUL1: begin
            prod_in  = mul_ap;
            state_in = ST_ERR0;
         end
         ST_ERR0: begin
            e_in     = x_ext - prod_ff;
            state_in = (prev_ff == 32'sd0) ? ST_MUL2 : ST_SCALE;
         end
         ST_SCALE: begin
            // |t| = |e0| >> 16, step magnitude = rate * |t| / |p|
            num_in   = 63'(cfg.adapt_rate * e_mag[62:16]);
            neg_in   = e_ff[63] ^ prev_ff[31];
            state_in = ST_STARTA;
         end
         ST_STARTA: begin
            div_start = 1'b1;
            state_in  = ST_DIVA;
         end
         ST_DIVA: begin
            if (div_done) begin
               coeff_in = sat32({{33{coeff_ff[31]}}, coeff_ff} + delta);
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            prod_in  = mul_ap;
            state_in = ST_RES;
         end
         ST_RES: begin
            e_in     = x_ext - prod_ff;
            plast_in = lres_ff;
            lres_in  = sat32(e_adj >>> 24);
            prev_in  = x_ff;
            head_in  = head_norm;
            state_in = ST_RD0;
         end
         ST_RD0: begin
            rd_addr  = head_ff;
            state_in = ST_RD1;
         end
         ST_RD1: begin
            rd_addr  = head_next;
            old0_in  = rd_data_ff;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            old1_in  = rd_data_ff;
            wr_en    = 1'b1;
            step_in  = 2'd0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            sq_in    = sq_op * sq_op;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            case (step_ff)
               2'd0: s_in = s_ff + SUM_W'(sq_ff);
               2'd1: if (fill_ff != '0) d_in = d_ff + SUM_W'(sq_ff);
               2'd2: if (fill_ff == win) s_in = s_ff - SUM_W'(sq_ff);
               default: if (fill_ff == win) d_in = d_ff - SUM_W'(sq_ff);
            endcase
            if (step_ff == 2'd3) begin
               head_in = head_next;
               if (fill_ff < win) fill_in = fill_ff + FILL_W'(1);
               state_in = ST_CHK;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = ST_SQ;
            end
         end
         ST_CHK: begin
            if (32'(fill_ff) >= 32'(cfg.min_fill)) begin
               valid_in = 1'b1;
               if (s_ff == '0) begin
                  dw_in    = DW_TWO;
                  state_in = ST_BAND;
               end else if ({2'b00, d_ff} >= {s_ff, 2'b00}) begin
                  dw_in    = DW_FOUR;
                  state_in = ST_BAND;
               end else begin
                  // dividend D*4096 with D/4 preloaded, quotient below 2^14
                  div_start = 1'b1;
                  div_rem   = d_ff >> 2;
                  div_low   = {d_ff[1:0], 62'd0};
                  div_den   = s_ff;
                  div_steps = 7'd14;
                  state_in  = ST_DIVB;
               end
            end else begin
               valid_in     = 1'b0;
               alarm_in     = 1'b0;
               dw_in        = DW_TWO;
               last_stat_in = DW_TWO;
               state_in     = ST_OUT;
            end
         end
         ST_DIVB: begin
            if (div_done) begin
               dw_in    = div_quot[14:0];
               state_in = ST_BAND;
            end
         end
         ST_BAND: begin
            alarm_in     = !in_ok && inband_ff;
            if (!in_ok && inband_ff) atot_in = atot_ff + 32'd1;
            inband_in    = in_ok;
            last_stat_in = dw_ff;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // window write empties the ring
      if (ring_clear) begin
         head_in = '0;
         fill_in = '0;
         s_in    = '0;
         d_in    = '0;
      end
   end

   always_comb begin
      rvalid_in = rvalid_ff;
      if (load) begin
         rvalid_in = 1'b1;
      end else if (!rsp_stall) begin
         rvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[head_ff] <= lres_ff;
      end
      rd_data_ff <= ring_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         coeff_ff     <= '0;
         lres_ff      <= '0;
         inband_ff    <= 1'b1;
         last_stat_ff <= DW_TWO;
         atot_ff      <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         s_ff         <= '0;
         d_ff         <= '0;
         rvalid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         coeff_ff     <= coeff_in;
         lres_ff      <= lres_in;
         inband_ff    <= inband_in;
         last_stat_ff <= last_stat_in;
         atot_ff      <= atot_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         s_ff         <= s_in;
         d_ff         <= d_in;
         rvalid_ff    <= rvalid_in;
      end
      x_ff     <= x_in;
      cnt_ff   <= cnt_in;
      plast_ff <= plast_in;
      old0_ff  <= old0_in;
      old1_ff  <= old1_in;
      prod_ff  <= prod_in;
      e_ff     <= e_in;
      num_ff   <= num_in;
      neg_ff   <= neg_in;
      dw_ff    <= dw_in;
      valid_ff <= valid_in;
      alarm_ff <= alarm_in;
      sq_ff    <= sq_in;
      step_ff  <= step_in;
      if (load) begin
         rdw_ff    <= dw_ff;
         rdwv_ff   <= valid_ff;
         rcoeff_ff <= coeff_ff;
         rres_ff   <= lres_ff;
         ralarm_ff <= alarm_ff;
         racnt_ff  <= atot_ff;
         ricnt_ff  <= cnt_ff;
      end
   end

   assign rsp_valid       = rvalid_ff;
   assign rsp_dw_stat     = rdw_ff;
   assign rsp_dw_valid    = rdwv_ff;
   assign rsp_ar_coeff    = rcoeff_ff;
   assign rsp_residual    = rres_ff;
   assign rsp_alarm       = ralarm_ff;
   assign rsp_alarm_count = racnt_ff;
   assign rsp_item_count  = ricnt_ff;

endmodule
`default_nettype wire

### src/residual_autocorrelation_monitor.sv
// Channel   Handshake          Payload
// req       req_valid/stall    req_sample (signed Q16.16)
// rsp       rsp_valid/stall    dw_stat, dw_valid, ar_coeff, residual, alarm, counts
// csr       csr_valid/ready    csr_index, csr_wdata
//
// The first transaction after reset only seeds the predictor. Every later one does
// the ring reads and four squares on one multiplier, and uses the bit-serial divider
// where needed: 63 quotient bits for the coefficient step and 14 for the statistic.
// Synchronous active-high reset; no clearing pass (ring contents tracked by fill).
// A two-entry queue takes new transactions while the back end works or the
// result register is stalled.
// Top level; depends on rac_pkg, rac_front, rac_fifo, rac_back.
`timescale 1ns / 1ps
`default_nettype none
module residual_autocorrelation_monitor
   import rac_pkg::*;
#(
   parameter int WINDOW_MAX = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_sample,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [14:0]             rsp_dw_stat,
   output logic                    rsp_dw_valid,
   output logic signed [31:0]      rsp_ar_coeff,
   output logic signed [31:0]      rsp_residual,
   output logic                    rsp_alarm,
   output logic [31:0]             rsp_alarm_count,
   output logic [31:0]             rsp_item_count,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     csr_wr, ring_clear;
   logic     q_full, q_push, q_nonempty, q_pop;
   item_type q_in_item, q_head_item;

   assign csr_ready  = 1'b1;
   assign csr_wr     = csr_valid & csr_ready;
   assign ring_clear = csr_wr && (csr_index == CSR_WINDOW);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_index)
            CSR_WINDOW:    cfg_in.window_size = csr_wdata[6:0];
            CSR_MIN_FILL:  cfg_in.min_fill    = csr_wdata[6:0];
            CSR_ADAPT:     cfg_in.adapt_rate  = csr_wdata;
            CSR_STAT_LOW:  cfg_in.stat_low    = csr_wdata[14:0];
            CSR_STAT_HIGH: cfg_in.stat_high   = csr_wdata[14:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_size <= WINDOW_RST;
         cfg_ff.min_fill    <= MIN_FILL_RST;
         cfg_ff.adapt_rate  <= ADAPT_RST;
         cfg_ff.stat_low    <= STAT_LOW_RST;
         cfg_ff.stat_high   <= STAT_HIGH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rac_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_in_item)
   );

   rac_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .nonempty  (q_nonempty),
      .pop       (q_pop),
      .head_item (q_head_item)
   );

   rac_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .ring_clear      (ring_clear),
      .q_nonempty      (q_nonempty),
      .q_item          (q_head_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_dw_stat     (rsp_dw_stat),
      .rsp_dw_valid    (rsp_dw_valid),
      .rsp_ar_coeff    (rsp_ar_coeff),
      .rsp_residual    (rsp_residual),
      .rsp_alarm       (rsp_alarm),
      .rsp_alarm_count (rsp_alarm_count),
      .rsp_item_count  (rsp_item_count)
   );

`ifndef NO_ASSERTIONS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_nonempty)
      else $error("queue popped while empty");

   a_alarm_needs_stat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_alarm) |-> rsp_dw_valid)
      else $error("alarm without a computed statistic");

   a_stat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_dw_stat <= DW_FOUR))
      else $error("statistic above 4.0");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_dw_stat) &&
         $stable(rsp_item_count)))
      else $error("stalled result changed");
`endif

endmodule
`default_nettype wire
